/* rtl/core/bta_pkg.sv */
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, constants and codes of the boundary tag heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

  // heap geometry and list sizes
  localparam int HEAP_BYTES = 65536;
  localparam int LIST_SLOTS = 8;
  localparam int TAG_BYTES  = 16;

  // derived widths
  localparam int ADDR_W = $clog2(HEAP_BYTES);
  localparam int P_W    = ADDR_W + 1;
  localparam int SUM_W  = 18;
  localparam int CNT_W  = $clog2(LIST_SLOTS + 1);
  localparam int IDX_W  = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;

  // fixed field widths
  localparam int SIZE_W = 16;
  localparam int REQ_W  = 17;
  localparam int OFF_W  = 16;
  localparam int THR_W  = 17;

  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(1000);

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FAIL   = 2'd1;
  localparam logic [1:0] ST_IGNORE = 2'd2;

  // request and result payloads
  typedef struct packed {
    logic             req_type;
    logic [REQ_W-1:0] req_size;
    logic [OFF_W-1:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] address;
  } rsp_t;

  // one header tag as held in the tag store
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } tag_t;

  localparam int TAG_W = SIZE_W + 1;

  // datapath operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_INIT_WR,
    DP_LOAD,
    DP_LIST_RD,
    DP_IDX_INC,
    DP_WALK_INIT,
    DP_WALK_RD,
    DP_WALK_STEP,
    DP_CAPTURE,
    DP_DROP_P,
    DP_SPLIT_HEAD,
    DP_SPLIT_REM,
    DP_MARK_USED,
    DP_MERGE_PREV,
    DP_NEXT_RD,
    DP_MERGE_NEXT,
    DP_FREE_WR,
    DP_FREE_PUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       res_valid;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free_req;
    logic size_bad;
    logic off_bad;
    logic idx_end;
    logic fit;
    logic p_end;
    logic chain_bad;
    logic at_target;
    logic past_target;
    logic rd_free;
    logic can_split;
    logic prev_merge;
    logic nx_in;
    logic nx_ok;
  } dp_stat_t;

  // controller states
  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_L_SCAN,
    S_L_WAIT,
    S_W_RD,
    S_W_WAIT,
    S_CLAIM_DROP,
    S_SPLIT_HEAD,
    S_SPLIT_REM,
    S_MARK_USED,
    S_F_RD,
    S_F_WAIT,
    S_F_PREV,
    S_F_NX_RD,
    S_F_NX_WAIT,
    S_F_WR,
    S_F_PUT
  } ctl_state_t;

endpackage

`default_nettype wire

/* rtl/core/bta_ram.sv */
// ----------------------------------------------------------------------------
// bta_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/bta_dp.sv */
// ----------------------------------------------------------------------------
// bta_dp
// Allocator datapath: tag store, fast lists, walk registers and result.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire bta_pkg::dp_cmd_t         cmd,
  input  wire bta_pkg::req_t            req,
  input  wire logic                     cfg_we,
  input  wire logic [bta_pkg::THR_W-1:0] cfg_wdata,
  output      bta_pkg::dp_stat_t        stat,
  output      logic                     done,
  output      bta_pkg::rsp_t            result
);

  typedef logic [15:0] list_t [bta_pkg::LIST_SLOTS];

  localparam logic [bta_pkg::SUM_W-1:0] HEAP_S = bta_pkg::SUM_W'(bta_pkg::HEAP_BYTES);
  localparam logic [bta_pkg::SUM_W-1:0] TWO_T  = bta_pkg::SUM_W'(2 * bta_pkg::TAG_BYTES);
  localparam logic [bta_pkg::SUM_W-1:0] ONE_T  = bta_pkg::SUM_W'(bta_pkg::TAG_BYTES);

  // request and walk registers
  logic                       type_r;
  logic [bta_pkg::REQ_W-1:0]  size_r;
  logic [bta_pkg::OFF_W-1:0]  off_r;
  logic [bta_pkg::P_W-1:0]    target;
  logic                       big_sel;
  logic [bta_pkg::P_W-1:0]    p;
  logic [bta_pkg::P_W-1:0]    prev;
  logic [bta_pkg::SIZE_W-1:0] prev_s;
  logic                       prev_free;
  logic                       have_prev;
  logic [bta_pkg::SIZE_W-1:0] s;
  logic [bta_pkg::CNT_W-1:0]  idx;
  logic [bta_pkg::THR_W-1:0]  big_threshold;

  list_t                      small_list;
  list_t                      big_list;
  logic [bta_pkg::CNT_W-1:0]  small_count;
  logic [bta_pkg::CNT_W-1:0]  big_count;

  // tag store ports
  logic                        mem_we;
  logic [bta_pkg::ADDR_W-1:0]  mem_waddr;
  bta_pkg::tag_t               mem_wdata;
  logic [bta_pkg::ADDR_W-1:0]  mem_raddr;
  logic [bta_pkg::TAG_W-1:0]   mem_rdata;
  bta_pkg::tag_t               rd;

  bta_ram #(
    .WIDTH (bta_pkg::TAG_W),
    .DEPTH (bta_pkg::HEAP_BYTES)
  ) u_tags (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd = bta_pkg::tag_t'(mem_rdata);

  // common sums
  logic [bta_pkg::SUM_W-1:0] p_ext;
  logic [bta_pkg::SUM_W-1:0] s_ext;
  logic [bta_pkg::SUM_W-1:0] req_ext;
  logic [bta_pkg::SUM_W-1:0] nx;
  logic [bta_pkg::SUM_W-1:0] rem_addr;
  logic [bta_pkg::SUM_W-1:0] rem_size;
  logic [15:0]               list_entry;
  logic [bta_pkg::CNT_W-1:0] sel_count;

  assign p_ext    = bta_pkg::SUM_W'(p);
  assign s_ext    = bta_pkg::SUM_W'(s);
  assign req_ext  = bta_pkg::SUM_W'(size_r);
  assign nx       = p_ext + TWO_T + s_ext;
  assign rem_addr = p_ext + TWO_T + req_ext;
  assign rem_size = s_ext - req_ext - TWO_T;
  assign sel_count  = big_sel ? big_count : small_count;
  assign list_entry = big_sel ? big_list[idx[bta_pkg::IDX_W-1:0]]
                              : small_list[idx[bta_pkg::IDX_W-1:0]];

  // offsets below one tag cannot be a payload
  logic off_small;
  assign off_small = off_r < bta_pkg::OFF_W'(bta_pkg::TAG_BYTES);

  // status towards the controller
  always_comb begin
    stat.is_free_req = type_r;
    stat.size_bad    = (size_r == '0) || (size_r > bta_pkg::REQ_W'(bta_pkg::HEAP_BYTES));
    stat.off_bad     = type_r && off_small;
    stat.idx_end     = idx >= sel_count;
    stat.fit         = rd.free && (bta_pkg::REQ_W'(rd.size) >= size_r);
    stat.p_end       = (p_ext + TWO_T) > HEAP_S;
    stat.chain_bad   = (p_ext + TWO_T + bta_pkg::SUM_W'(rd.size)) > HEAP_S;
    stat.at_target   = p == target;
    stat.past_target = p > target;
    stat.rd_free     = rd.free;
    stat.can_split   = s_ext >= (req_ext + TWO_T + bta_pkg::SUM_W'(1));
    stat.prev_merge  = have_prev && prev_free;
    stat.nx_in       = (nx + TWO_T) <= HEAP_S;
    stat.nx_ok       = ((nx + TWO_T + bta_pkg::SUM_W'(rd.size)) <= HEAP_S) && rd.free;
  end

  // tag store read and write selection
  always_comb begin
    mem_raddr = bta_pkg::ADDR_W'(p);
    mem_we    = 1'b0;
    mem_waddr = bta_pkg::ADDR_W'(p);
    mem_wdata = '{free: 1'b0, size: s};
    case (cmd.op)
      bta_pkg::DP_LIST_RD: mem_raddr = bta_pkg::ADDR_W'(list_entry);
      bta_pkg::DP_NEXT_RD: mem_raddr = bta_pkg::ADDR_W'(nx);
      bta_pkg::DP_INIT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{free: 1'b1,
                      size: bta_pkg::SIZE_W'(bta_pkg::HEAP_BYTES - 2 * bta_pkg::TAG_BYTES)};
      end
      bta_pkg::DP_SPLIT_HEAD: begin
        mem_we    = 1'b1;
        mem_wdata = '{free: 1'b0, size: bta_pkg::SIZE_W'(size_r)};
      end
      bta_pkg::DP_SPLIT_REM: begin
        mem_we    = 1'b1;
        mem_waddr = bta_pkg::ADDR_W'(rem_addr);
        mem_wdata = '{free: 1'b1, size: bta_pkg::SIZE_W'(rem_size)};
      end
      bta_pkg::DP_MARK_USED: mem_we = 1'b1;
      bta_pkg::DP_FREE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = '{free: 1'b1, size: s};
      end
      default: ;
    endcase
  end

  // walk and request registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      bta_pkg::DP_LOAD: begin
        type_r    <= req.req_type;
        size_r    <= req.req_size;
        off_r     <= req.payload_offset;
        target    <= bta_pkg::P_W'(req.payload_offset) - bta_pkg::P_W'(bta_pkg::TAG_BYTES);
        big_sel   <= req.req_size > big_threshold;
        idx       <= '0;
        have_prev <= 1'b0;
        p         <= '0;
      end
      bta_pkg::DP_LIST_RD: p <= bta_pkg::P_W'(list_entry);
      bta_pkg::DP_IDX_INC: idx <= idx + bta_pkg::CNT_W'(1);
      bta_pkg::DP_WALK_INIT: begin
        p         <= '0;
        have_prev <= 1'b0;
      end
      bta_pkg::DP_WALK_STEP: begin
        prev      <= p;
        prev_s    <= rd.size;
        prev_free <= rd.free;
        have_prev <= 1'b1;
        p         <= bta_pkg::P_W'(p_ext + TWO_T + bta_pkg::SUM_W'(rd.size));
      end
      bta_pkg::DP_CAPTURE: s <= rd.size;
      bta_pkg::DP_MERGE_PREV: begin
        s <= bta_pkg::SIZE_W'(bta_pkg::SUM_W'(prev_s) + s_ext + TWO_T);
        p <= prev;
      end
      bta_pkg::DP_MERGE_NEXT: s <= bta_pkg::SIZE_W'(s_ext + bta_pkg::SUM_W'(rd.size) + TWO_T);
      default: ;
    endcase
  end

  // fast list maintenance
  logic        drop_en;
  logic [15:0] drop_addr;
  logic        put_en;
  logic [15:0] put_addr;
  logic [bta_pkg::SUM_W-1:0] put_size;

  always_comb begin
    drop_en   = 1'b0;
    drop_addr = 16'(p);
    put_en    = 1'b0;
    put_addr  = 16'(p);
    put_size  = s_ext;
    case (cmd.op)
      bta_pkg::DP_DROP_P:     drop_en = 1'b1;
      bta_pkg::DP_FREE_WR:    drop_en = 1'b1;
      bta_pkg::DP_MERGE_PREV: begin
        drop_en   = 1'b1;
        drop_addr = 16'(prev);
      end
      bta_pkg::DP_MERGE_NEXT: begin
        drop_en   = 1'b1;
        drop_addr = 16'(nx);
      end
      bta_pkg::DP_SPLIT_REM: begin
        put_en   = 1'b1;
        put_addr = 16'(rem_addr);
        put_size = rem_size;
      end
      bta_pkg::DP_FREE_PUT: put_en = 1'b1;
      default: ;
    endcase
  end

  // lists with the dropped address taken out and the rest moved up
  list_t small_drop;
  list_t big_drop;
  logic  small_seen;
  logic  big_seen;

  always_comb begin
    small_seen = 1'b0;
    big_seen   = 1'b0;
    for (int j = 0; j < bta_pkg::LIST_SLOTS; j++) begin
      if (bta_pkg::CNT_W'(j) < small_count && small_list[j] == drop_addr) small_seen = 1'b1;
      if (bta_pkg::CNT_W'(j) < big_count && big_list[j] == drop_addr) big_seen = 1'b1;
      if (small_seen && (j + 1 < bta_pkg::LIST_SLOTS))
        small_drop[j] = small_list[(j + 1) % bta_pkg::LIST_SLOTS];
      else
        small_drop[j] = small_list[j];
      if (big_seen && (j + 1 < bta_pkg::LIST_SLOTS))
        big_drop[j] = big_list[(j + 1) % bta_pkg::LIST_SLOTS];
      else
        big_drop[j] = big_list[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_count <= '0;
      big_count   <= bta_pkg::CNT_W'(1);
      big_list[0] <= '0;
    end else if (drop_en) begin
      small_list  <= small_drop;
      big_list    <= big_drop;
      small_count <= small_count - bta_pkg::CNT_W'(small_seen);
      big_count   <= big_count - bta_pkg::CNT_W'(big_seen);
    end else if (put_en) begin
      if (put_size > bta_pkg::SUM_W'(big_threshold)) begin
        if (big_count < bta_pkg::CNT_W'(bta_pkg::LIST_SLOTS)) begin
          big_list[big_count[bta_pkg::IDX_W-1:0]] <= put_addr;
          big_count <= big_count + bta_pkg::CNT_W'(1);
        end
      end else if (small_count < bta_pkg::CNT_W'(bta_pkg::LIST_SLOTS)) begin
        small_list[small_count[bta_pkg::IDX_W-1:0]] <= put_addr;
        small_count <= small_count + bta_pkg::CNT_W'(1);
      end
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      big_threshold <= bta_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      big_threshold <= cfg_wdata;
    end
  end

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_valid) begin
      result.status  <= cmd.res_status;
      result.address <= (cmd.res_status == bta_pkg::ST_DONE && !type_r)
                        ? 16'(p_ext + ONE_T) : 16'd0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bta_ctrl.sv */
// ----------------------------------------------------------------------------
// bta_ctrl
// Allocator controller: sequences list scan, chain walk, split and merge.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire bta_pkg::dp_stat_t stat,
  output      bta_pkg::dp_cmd_t  cmd,
  output      logic              busy
);

  bta_pkg::ctl_state_t state;
  bta_pkg::ctl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bta_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = rst || (state != bta_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd.op         = bta_pkg::DP_NOP;
    cmd.res_valid  = 1'b0;
    cmd.res_status = bta_pkg::ST_DONE;
    case (state)
      bta_pkg::S_INIT: begin
        cmd.op     = bta_pkg::DP_INIT_WR;
        state_next = bta_pkg::S_IDLE;
      end
      bta_pkg::S_IDLE: begin
        if (start) begin
          cmd.op     = bta_pkg::DP_LOAD;
          state_next = bta_pkg::S_DECIDE;
        end
      end
      bta_pkg::S_DECIDE: begin
        if (stat.is_free_req) begin
          if (stat.off_bad) begin
            cmd.res_valid  = 1'b1;
            cmd.res_status = bta_pkg::ST_IGNORE;
            state_next     = bta_pkg::S_IDLE;
          end else begin
            cmd.op     = bta_pkg::DP_WALK_INIT;
            state_next = bta_pkg::S_F_RD;
          end
        end else if (stat.size_bad) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = bta_pkg::ST_FAIL;
          state_next     = bta_pkg::S_IDLE;
        end else begin
          state_next = bta_pkg::S_L_SCAN;
        end
      end
      // fast list scan
      bta_pkg::S_L_SCAN: begin
        if (stat.idx_end) begin
          cmd.op     = bta_pkg::DP_WALK_INIT;
          state_next = bta_pkg::S_W_RD;
        end else begin
          cmd.op     = bta_pkg::DP_LIST_RD;
          state_next = bta_pkg::S_L_WAIT;
        end
      end
      bta_pkg::S_L_WAIT: begin
        if (stat.fit) begin
          cmd.op     = bta_pkg::DP_CAPTURE;
          state_next = bta_pkg::S_CLAIM_DROP;
        end else begin
          cmd.op     = bta_pkg::DP_IDX_INC;
          state_next = bta_pkg::S_L_SCAN;
        end
      end
      // first-fit chain walk
      bta_pkg::S_W_RD: begin
        if (stat.p_end) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = bta_pkg::ST_FAIL;
          state_next     = bta_pkg::S_IDLE;
        end else begin
          cmd.op     = bta_pkg::DP_WALK_RD;
          state_next = bta_pkg::S_W_WAIT;
        end
      end
      bta_pkg::S_W_WAIT: begin
        if (stat.chain_bad) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = bta_pkg::ST_FAIL;
          state_next     = bta_pkg::S_IDLE;
        end else if (stat.fit) begin
          cmd.op     = bta_pkg::DP_CAPTURE;
          state_next = bta_pkg::S_CLAIM_DROP;
        end else begin
          cmd.op     = bta_pkg::DP_WALK_STEP;
          state_next = bta_pkg::S_W_RD;
        end
      end
      // claim the chosen block
      bta_pkg::S_CLAIM_DROP: begin
        cmd.op     = bta_pkg::DP_DROP_P;
        state_next = stat.can_split ? bta_pkg::S_SPLIT_HEAD : bta_pkg::S_MARK_USED;
      end
      bta_pkg::S_SPLIT_HEAD: begin
        cmd.op     = bta_pkg::DP_SPLIT_HEAD;
        state_next = bta_pkg::S_SPLIT_REM;
      end
      bta_pkg::S_SPLIT_REM: begin
        cmd.op        = bta_pkg::DP_SPLIT_REM;
        cmd.res_valid = 1'b1;
        state_next    = bta_pkg::S_IDLE;
      end
      bta_pkg::S_MARK_USED: begin
        cmd.op        = bta_pkg::DP_MARK_USED;
        cmd.res_valid = 1'b1;
        state_next    = bta_pkg::S_IDLE;
      end
      // free: find the block in the chain
      bta_pkg::S_F_RD: begin
        if (stat.p_end) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = bta_pkg::ST_IGNORE;
          state_next     = bta_pkg::S_IDLE;
        end else begin
          cmd.op     = bta_pkg::DP_WALK_RD;
          state_next = bta_pkg::S_F_WAIT;
        end
      end
      bta_pkg::S_F_WAIT: begin
        if (stat.chain_bad || (!stat.at_target && stat.past_target) ||
            (stat.at_target && stat.rd_free)) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = bta_pkg::ST_IGNORE;
          state_next     = bta_pkg::S_IDLE;
        end else if (stat.at_target) begin
          cmd.op     = bta_pkg::DP_CAPTURE;
          state_next = bta_pkg::S_F_PREV;
        end else begin
          cmd.op     = bta_pkg::DP_WALK_STEP;
          state_next = bta_pkg::S_F_RD;
        end
      end
      // coalesce with neighbours
      bta_pkg::S_F_PREV: begin
        if (stat.prev_merge) cmd.op = bta_pkg::DP_MERGE_PREV;
        state_next = bta_pkg::S_F_NX_RD;
      end
      bta_pkg::S_F_NX_RD: begin
        if (stat.nx_in) begin
          cmd.op     = bta_pkg::DP_NEXT_RD;
          state_next = bta_pkg::S_F_NX_WAIT;
        end else begin
          state_next = bta_pkg::S_F_WR;
        end
      end
      bta_pkg::S_F_NX_WAIT: begin
        if (stat.nx_ok) cmd.op = bta_pkg::DP_MERGE_NEXT;
        state_next = bta_pkg::S_F_WR;
      end
      bta_pkg::S_F_WR: begin
        cmd.op     = bta_pkg::DP_FREE_WR;
        state_next = bta_pkg::S_F_PUT;
      end
      bta_pkg::S_F_PUT: begin
        cmd.op        = bta_pkg::DP_FREE_PUT;
        cmd.res_valid = 1'b1;
        state_next    = bta_pkg::S_IDLE;
      end
      default: state_next = bta_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/boundary_tag_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_unit
// Heap allocator with boundary tags, two fast lists and first-fit fallback.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req           taken when start && !busy
//  result    done, result               one cycle strobe, cannot be held off
//  config    cfg_we, cfg_wdata          written when cfg_we
//
// Every request passes through a decode state after it is taken; a rejected
// request ends there. An allocate then tries the fast list slots one by one,
// leaves the list when nothing fits, walks the chain block by block, fails
// when the walk runs off the end, and claims the block it found, with or
// without a split. A free walks the chain block by block up to the target,
// then merges with its neighbours and relists the block. Each slot or block
// takes a header read and a wait for its data; one read is in flight at a time.
// After reset the S_INIT state writes the initial header; busy is high meanwhile.
// The result strobe is registered from the last step and comes in the cycle after it; busy falls with it.
`default_nettype none

module boundary_tag_heap_allocator_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire bta_pkg::req_t             req,
  input  wire logic                      cfg_we,
  input  wire logic [bta_pkg::THR_W-1:0] cfg_wdata,
  output      logic                      done,
  output      bta_pkg::rsp_t             result
);

  bta_pkg::dp_cmd_t  cmd;
  bta_pkg::dp_stat_t stat;

  bta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bta_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

  // a result only follows busy work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // only a finished allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != bta_pkg::ST_DONE) |-> (result.address == 16'd0))
    else $error("address on a failed request");

  // no two result strobes back to back
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results for one request");

endmodule

`default_nettype wire
